@@ src/alphabet_shift_cipher_core_macros.svh @@
// Assertion macros shared by the alphabet shift cipher checker.
`ifndef ALPHABET_SHIFT_CIPHER_CORE_MACROS_SVH
`define ALPHABET_SHIFT_CIPHER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define ASC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define ASC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/asc_pkg.sv @@
// Shared types and constants of the alphabet shift cipher.
`timescale 1ns / 1ps
`default_nettype none

package asc_pkg;

  localparam int unsigned DEF_SIZE  = 64;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned POS_W     = 6;
  localparam int unsigned ASIZE_W   = 7;
  localparam int unsigned SHIFT_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CODE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR   = 1'b1;

endpackage

`default_nettype wire

@@ src/alphabet_shift_cipher_core.sv @@
// Shift cipher over a custom ordered alphabet held in a symbol memory.
`timescale 1ns / 1ps
`default_nettype none

// The alphabet lives in a SIZE x 8 memory with a registered read.
// Add, code and query scan the held symbols one entry per cycle. Code, on a
// hit, then reduces the key modulo count in 16 restoring steps (one key bit
// per cycle), where count is the number of symbols held, and reads the target
// entry through an address state and a read state. Clear and add to a full
// alphabet go straight to the output state. One item is in work at a time; a
// finished beat waits in the output register while the next item is accepted,
// and a result that finds the output register still stalled waits with the
// input stalled behind it.
// Configuration has no wait states and is to be written only while the block
// is idle.
module alphabet_shift_cipher_core
  import asc_pkg::*;
#(
  parameter int unsigned SIZE = DEF_SIZE
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [SHIFT_W-1:0]     cfg_data_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire  [1:0]             op_i,
  input  wire  [SYM_W-1:0]       symbol_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output logic [SYM_W-1:0]       out_symbol_o,
  output logic [POS_W-1:0]       position_o,
  output logic [ASIZE_W-1:0]     alphabet_size_o,
  output logic [1:0]             status_o
);

  localparam int unsigned CntW  = $clog2(SIZE + 1);
  localparam int unsigned IdxW  = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam int unsigned ModCW = $clog2(SHIFT_W);
  localparam logic [CntW-1:0]  SizeCnt  = CntW'(SIZE);
  localparam logic [ModCW-1:0] ModLast  = ModCW'(SHIFT_W - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_ADDR   = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  // Control state.
  logic [2:0]         state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    issue_q, issue_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [ModCW-1:0]   mod_cnt_q, mod_cnt_d;
  logic               out_valid_q, out_valid_d;
  logic [SHIFT_W-1:0] shift_q;
  logic               dir_q;

  // Payload registers.
  op_e                op_q, op_d;
  logic [SYM_W-1:0]   sym_q, sym_d;
  logic [IdxW-1:0]    cmp_idx_q, cmp_idx_d;
  logic [IdxW-1:0]    res_pos_q, res_pos_d;
  status_e            res_stat_q, res_stat_d;
  logic [SYM_W-1:0]   res_sym_q, res_sym_d;
  logic [CntW-1:0]    rem_q, rem_d;
  logic [SHIFT_W-1:0] div_q, div_d;
  logic [SYM_W-1:0]   out_sym_q, out_sym_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic [ASIZE_W-1:0] out_size_q, out_size_d;
  status_e            out_stat_q, out_stat_d;

  // Symbol memory.
  logic [SYM_W-1:0]   mem [SIZE];
  logic [SYM_W-1:0]   mem_rdata_q;
  logic               rd_en, wr_en;
  logic [IdxW-1:0]    rd_addr, wr_addr;

  logic               in_acc, hit, out_free;
  logic [CntW:0]      mod_trial, key_sum, key_idx;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign hit         = cmp_vld_q && (mem_rdata_q == sym_q);

  // One restoring step of the key reduction modulo the symbol count.
  assign mod_trial = {rem_q, div_q[SHIFT_W-1]};

  // The key is already below count and so is the position: one correction.
  always_comb begin
    if (dir_q) begin
      key_sum = (CntW+1)'(res_pos_q) + {1'b0, rem_q};
    end else begin
      key_sum = (CntW+1)'(res_pos_q) + {1'b0, count_q} - {1'b0, rem_q};
    end
    if (key_sum >= {1'b0, count_q}) begin
      key_idx = key_sum - {1'b0, count_q};
    end else begin
      key_idx = key_sum;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    issue_d     = issue_q;
    cmp_vld_d   = 1'b0;
    mod_cnt_d   = mod_cnt_q;
    out_valid_d = out_valid_q;
    op_d        = op_q;
    sym_d       = sym_q;
    cmp_idx_d   = cmp_idx_q;
    res_pos_d   = res_pos_q;
    res_stat_d  = res_stat_q;
    res_sym_d   = res_sym_q;
    rem_d       = rem_q;
    div_d       = div_q;
    out_sym_d   = out_sym_q;
    out_pos_d   = out_pos_q;
    out_size_d  = out_size_q;
    out_stat_d  = out_stat_q;
    rd_en       = 1'b0;
    rd_addr     = issue_q[IdxW-1:0];
    wr_en       = 1'b0;
    wr_addr     = count_q[IdxW-1:0];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d       = op_e'(op_i);
          sym_d      = symbol_i;
          res_pos_d  = '0;
          res_sym_d  = '0;
          res_stat_d = STAT_OK;
          issue_d    = '0;
          case (op_e'(op_i))
            OP_CLEAR: begin
              count_d = '0;
              state_d = S_FIN;
            end
            OP_ADD: begin
              if (count_q >= SizeCnt) begin
                res_stat_d = STAT_FULL;
                state_d    = S_FIN;
              end else begin
                state_d = S_SEARCH;
              end
            end
            default: begin
              state_d = S_SEARCH;
            end
          endcase
        end
      end

      // Reads run one entry ahead of the compare on the registered data.
      S_SEARCH: begin
        if (hit) begin
          res_pos_d = cmp_idx_q;
          if (op_q == OP_CODE) begin
            rem_d     = '0;
            div_d     = shift_q;
            mod_cnt_d = '0;
            state_d   = S_MOD;
          end else begin
            state_d = S_FIN;
          end
        end else if (issue_q < count_q) begin
          rd_en     = 1'b1;
          cmp_vld_d = 1'b1;
          cmp_idx_d = issue_q[IdxW-1:0];
          issue_d   = issue_q + 1'b1;
        end else if (!cmp_vld_q) begin
          if (op_q == OP_ADD) begin
            wr_en     = 1'b1;
            res_pos_d = count_q[IdxW-1:0];
            count_d   = count_q + 1'b1;
          end else begin
            res_stat_d = STAT_MISSING;
          end
          state_d = S_FIN;
        end
      end

      S_MOD: begin
        if (mod_trial >= {1'b0, count_q}) begin
          rem_d = CntW'(mod_trial - {1'b0, count_q});
        end else begin
          rem_d = CntW'(mod_trial);
        end
        div_d     = div_q << 1;
        mod_cnt_d = mod_cnt_q + 1'b1;
        if (mod_cnt_q == ModLast) begin
          state_d = S_ADDR;
        end
      end

      S_ADDR: begin
        rd_en   = 1'b1;
        rd_addr = key_idx[IdxW-1:0];
        state_d = S_RD;
      end

      S_RD: begin
        res_sym_d = mem_rdata_q;
        state_d   = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sym_d   = res_sym_q;
          out_pos_d   = POS_W'(res_pos_q);
          out_size_d  = ASIZE_W'(count_q);
          out_stat_d  = res_stat_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      cmp_vld_q   <= 1'b0;
      mod_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      shift_q     <= '0;
      dir_q       <= 1'b1;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      issue_q     <= issue_d;
      cmp_vld_q   <= cmp_vld_d;
      mod_cnt_q   <= mod_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CFG_SHIFT: shift_q <= cfg_data_i;
          CFG_DIR:   dir_q   <= cfg_data_i[0];
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    sym_q      <= sym_d;
    cmp_idx_q  <= cmp_idx_d;
    res_pos_q  <= res_pos_d;
    res_stat_q <= res_stat_d;
    res_sym_q  <= res_sym_d;
    rem_q      <= rem_d;
    div_q      <= div_d;
    out_sym_q  <= out_sym_d;
    out_pos_q  <= out_pos_d;
    out_size_q <= out_size_d;
    out_stat_q <= out_stat_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= sym_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mem_rdata_q <= mem[rd_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_symbol_o    = out_sym_q;
  assign position_o      = out_pos_q;
  assign alphabet_size_o = out_size_q;
  assign status_o        = out_stat_q;

endmodule

`default_nettype wire

@@ src/asc_checker.sv @@
// Port-level checker for the alphabet shift cipher, bound into the cipher core module.
`timescale 1ns / 1ps
`default_nettype none

`include "alphabet_shift_cipher_core_macros.svh"

module asc_checker
  import asc_pkg::*;
#(
  parameter int unsigned SIZE = DEF_SIZE
) (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               out_valid_i,
  input wire               out_stall_i,
  input wire [SYM_W-1:0]   out_symbol_i,
  input wire [POS_W-1:0]   position_i,
  input wire [ASIZE_W-1:0] alphabet_size_i,
  input wire [1:0]         status_i
);

  localparam logic [ASIZE_W-1:0] SizeOut = ASIZE_W'(SIZE);

  // A stalled beat must stay put until it is taken.
  `ASC_ASSERT_NXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i && $stable(out_symbol_i) && $stable(position_i) && $stable(alphabet_size_i) && $stable(status_i), "output beat changed while stalled")

  `ASC_ASSERT_IMP(a_status_legal, out_valid_i, (status_i == STAT_OK || status_i == STAT_FULL || status_i == STAT_MISSING) && alphabet_size_i <= SIZE, "illegal status or size")

  // A missing symbol yields no coded symbol and no position.
  `ASC_ASSERT_IMP(a_missing_zero, out_valid_i && status_i == STAT_MISSING, out_symbol_i == '0 && position_i == '0, "missing beat carries data")

  // Full is only reported when the alphabet holds SIZE symbols.
  `ASC_ASSERT_IMP(a_full_size, out_valid_i && status_i == STAT_FULL, out_symbol_i == '0 && position_i == '0 && alphabet_size_i == SizeOut, "full beat with wrong size or data")

endmodule

bind alphabet_shift_cipher_core asc_checker #(
  .SIZE(SIZE)
) u_asc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_symbol_i   (out_symbol_o),
  .position_i     (position_o),
  .alphabet_size_i(alphabet_size_o),
  .status_i       (status_o)
);

`default_nettype wire

@@ bench/asc_cipher_checker.sv @@
// Watches the cipher channels, predicts every result beat and compares it field by field.
`timescale 1ns / 1ps

module asc_cipher_checker
  import asc_pkg::*;
#(
  parameter int unsigned SIZE = DEF_SIZE
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_valid_i,
  input  wire                  cfg_ready_i,
  input  wire  [CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [SHIFT_W-1:0]   cfg_data_i,
  input  wire                  in_valid_i,
  input  wire                  in_stall_i,
  input  wire  [1:0]           op_i,
  input  wire  [SYM_W-1:0]     symbol_i,
  input  wire                  out_valid_i,
  input  wire                  out_stall_i,
  input  wire  [SYM_W-1:0]     out_symbol_i,
  input  wire  [POS_W-1:0]     position_i,
  input  wire  [ASIZE_W-1:0]   alphabet_size_i,
  input  wire  [1:0]           status_i,
  output int unsigned          mismatches_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic [SYM_W-1:0]   out_symbol;
    logic [POS_W-1:0]   position;
    logic [ASIZE_W-1:0] alphabet_size;
    status_e            status;
  } cipher_beat_t;

  logic [SYM_W-1:0]   alpha_tbl [SIZE];
  int unsigned        held_count = 0;
  logic [SHIFT_W-1:0] key_shift  = '0;
  logic               encrypt    = 1'b1;
  cipher_beat_t       expected_q [$];

  // Applies one item to the alphabet copy and returns the beat it should produce.
  function automatic cipher_beat_t apply_item(op_e op, logic [SYM_W-1:0] sym);
    cipher_beat_t r;
    bit           hit;
    int unsigned  j;
    int unsigned  n;
    int unsigned  s;
    int unsigned  k;
    r   = '0;
    hit = 1'b0;
    j   = 0;
    for (int unsigned i = 0; i < held_count; i++) begin
      if (!hit && alpha_tbl[i] == sym) begin
        hit = 1'b1;
        j   = i;
      end
    end
    case (op)
      OP_ADD: begin
        if (held_count >= SIZE) begin
          r.status = STAT_FULL;
        end else if (hit) begin
          r.position = POS_W'(j);
        end else begin
          alpha_tbl[held_count] = sym;
          r.position = POS_W'(held_count);
          held_count++;
        end
      end
      OP_CODE: begin
        if (hit) begin
          n = held_count;
          s = key_shift % n;
          // Backward shift adds count first so the index never wraps below zero.
          k = encrypt ? (j + s) % n : (j + n - s) % n;
          r.out_symbol = alpha_tbl[k];
          r.position   = POS_W'(j);
        end else begin
          r.status = STAT_MISSING;
        end
      end
      OP_QUERY: begin
        if (hit) begin
          r.position = POS_W'(j);
        end else begin
          r.status = STAT_MISSING;
        end
      end
      default: begin
        held_count = 0;
      end
    endcase
    r.alphabet_size = ASIZE_W'(held_count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cipher_beat_t want;
    if (!rst_ni) begin
      expected_q.delete();
      held_count   = 0;
      key_shift    = '0;
      encrypt      = 1'b1;
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      // Results are checked before new items are queued, so a stray beat is never
      // matched against an item accepted at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          if (mismatches_o < 10) begin
            $display("%0t: result beat with nothing expected: sym %02h pos %0d size %0d st %0d",
                     $time, out_symbol_i, position_i, alphabet_size_i, status_i);
          end
          mismatches_o++;
        end else begin
          want = expected_q.pop_front();
          if (out_symbol_i !== want.out_symbol || position_i !== want.position ||
              alphabet_size_i !== want.alphabet_size || status_i !== want.status) begin
            if (mismatches_o < 10) begin
              $display("%0t: expected sym %02h pos %0d size %0d st %0d, got %02h %0d %0d %0d",
                       $time, want.out_symbol, want.position, want.alphabet_size,
                       want.status, out_symbol_i, position_i, alphabet_size_i, status_i);
            end
            mismatches_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SHIFT) begin
          key_shift = cfg_data_i;
        end else if (cfg_index_i == CFG_DIR) begin
          encrypt = cfg_data_i[0];
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_q.push_back(apply_item(op_e'(op_i), symbol_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

@@ bench/tb.sv @@
// Stimulus and verdict for the alphabet shift cipher core.
`timescale 1ns / 1ps

module tb;
  import asc_pkg::*;

  localparam int unsigned TABLE_SIZE  = DEF_SIZE;
  localparam int unsigned ITEMS       = 2000;
  localparam int unsigned RX_HOLD     = 600;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SHIFT;
  logic [SHIFT_W-1:0]   cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  op_e                  op_in     = OP_ADD;
  logic [SYM_W-1:0]     symbol_in = '0;
  logic                 out_stall = 1'b0;

  wire                  cfg_ready;
  wire                  in_stall;
  wire                  out_valid;
  wire  [SYM_W-1:0]     out_symbol;
  wire  [POS_W-1:0]     position;
  wire  [ASIZE_W-1:0]   alphabet_size;
  wire  [1:0]           status;
  int unsigned          mismatches;
  int unsigned          pending;

  bit                   hold_rx  = 1'b0;
  bit                   tx_quiet = 1'b0;
  bit                   hold_done;
  int unsigned          sent     = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  alphabet_shift_cipher_core #(
    .SIZE (TABLE_SIZE)
  ) u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (op_in),
    .symbol_i        (symbol_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_symbol_o    (out_symbol),
    .position_o      (position),
    .alphabet_size_o (alphabet_size),
    .status_o        (status)
  );

  asc_cipher_checker #(
    .SIZE (TABLE_SIZE)
  ) u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .op_i            (op_in),
    .symbol_i        (symbol_in),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_symbol_i    (out_symbol),
    .position_i      (position),
    .alphabet_size_i (alphabet_size),
    .status_i        (status),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  // Receiver back-pressure: free-running stretches, short stalls, rare long ones,
  // and one long hold-off on request so the core backs up into its input.
  initial begin : rx_stall_gen
    int unsigned len;
    @(posedge clk);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (RX_HOLD) @(posedge clk);
        hold_rx = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        len = $urandom_range(20, 200);
        repeat (len) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
        repeat (len) @(posedge clk);
        out_stall <= 1'b0;
        len = $urandom_range(1, 8);
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic int unsigned tx_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_quiet || r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 16);
    end
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return SHIFT_W'(1);
      3:       return SHIFT_W'($urandom_range(0, 130));
      default: return SHIFT_W'($urandom);
    endcase
  endfunction

  // Called at a rising edge; returns at the edge that accepted the beat or ended its gap.
  task automatic send_item(op_e op, logic [SYM_W-1:0] sym);
    int unsigned gap;
    in_valid  <= 1'b1;
    op_in     <= op;
    symbol_in <= sym;
    do @(posedge clk); while (in_stall);
    sent++;
    gap = tx_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic load_key(logic [SHIFT_W-1:0] shift, bit dir);
    logic [SHIFT_W-1:0] junk;
    junk      = SHIFT_W'($urandom);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_SHIFT;
    cfg_data  <= shift;
    do @(posedge clk); while (!cfg_ready);
    // Upper data bits are don't-care for the direction register.
    cfg_index <= CFG_DIR;
    cfg_data  <= {junk[SHIFT_W-1:1], dir};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Clears the alphabet, fills it with distinct symbols and then mostly codes and
  // looks up symbols that are held, with some misses, duplicates, overflows and clears.
  task automatic build_and_code(int unsigned ops);
    logic [SYM_W-1:0] held [$];
    bit   [255:0]     used;
    int unsigned      target;
    int unsigned      pick;
    logic [SYM_W-1:0] s;
    used = '0;
    send_item(OP_CLEAR, SYM_W'($urandom));
    pick = $urandom_range(0, 99);
    target = (pick < 25) ? TABLE_SIZE : (pick < 35) ? 1 : $urandom_range(2, 40);
    while (held.size() < target) begin
      do s = SYM_W'($urandom); while (used[s]);
      used[s] = 1'b1;
      held.push_back(s);
      send_item(OP_ADD, s);
    end
    repeat (ops) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        send_item(OP_CODE, held[$urandom_range(0, held.size() - 1)]);
      end else if (pick < 62) begin
        send_item(OP_QUERY, held[$urandom_range(0, held.size() - 1)]);
      end else if (pick < 72) begin
        do s = SYM_W'($urandom); while (used[s]);
        send_item((pick < 67) ? OP_CODE : OP_QUERY, s);
      end else if (pick < 82) begin
        send_item(OP_ADD, held[$urandom_range(0, held.size() - 1)]);
      end else if (pick < 96) begin
        do s = SYM_W'($urandom); while (used[s]);
        // On a full alphabet the add is refused and the symbol stays absent.
        if (held.size() < TABLE_SIZE) begin
          used[s] = 1'b1;
          held.push_back(s);
        end
        send_item(OP_ADD, s);
      end else begin
        send_item(OP_CLEAR, SYM_W'($urandom));
        held.delete();
        used = '0;
        s = SYM_W'($urandom);
        used[s] = 1'b1;
        held.push_back(s);
        send_item(OP_ADD, s);
      end
    end
  endtask

  initial begin : stimulus
    hold_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Empty alphabet, first adds, duplicates, hits and misses at the reset key.
    send_item(OP_CODE, 8'h41);
    send_item(OP_QUERY, 8'h41);
    send_item(OP_CLEAR, 8'h00);
    send_item(OP_ADD, 8'h00);
    send_item(OP_ADD, 8'hFF);
    send_item(OP_ADD, 8'h00);
    send_item(OP_QUERY, 8'hFF);
    send_item(OP_QUERY, 8'h80);
    send_item(OP_CODE, 8'h00);
    send_item(OP_CODE, 8'h7F);
    send_item(OP_ADD, 8'h55);
    send_item(OP_ADD, 8'hAA);
    send_item(OP_CODE, 8'hFF);
    drain();

    // Largest key, shifting backward.
    load_key('1, 1'b0);
    send_item(OP_CODE, 8'h00);
    send_item(OP_CODE, 8'hAA);
    send_item(OP_CODE, 8'h55);
    send_item(OP_CLEAR, 8'hFF);
    send_item(OP_CODE, 8'h00);
    drain();

    // A one-symbol alphabet maps every shift onto itself.
    load_key(SHIFT_W'(1), 1'b1);
    send_item(OP_ADD, 8'h01);
    send_item(OP_CODE, 8'h01);
    send_item(OP_QUERY, 8'h01);

    while (sent < ITEMS) begin
      drain();
      load_key(pick_shift(), 1'($urandom_range(0, 1)));
      tx_quiet = ($urandom_range(0, 4) == 0);
      if (!hold_done && sent > ITEMS / 3) begin
        hold_done = 1'b1;
        hold_rx   = 1'b1;
        tx_quiet  = 1'b1;
        build_and_code(20);
      end else if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(5, 30)) begin
          send_item(op_e'($urandom_range(0, 3)), SYM_W'($urandom));
        end
      end else begin
        build_and_code($urandom_range(10, 60));
      end
    end

    drain();
    repeat (100) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
